@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; compiled out with
// NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define PBA_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define PBA_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("assertion failed");
`else
`define PBA_ASSERT(lbl, clk, rst, prop)
`define PBA_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

@@ src/pba_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pba_pkg
// Types and codes shared by the page/block allocator modules.
// ----------------------------------------------------------------------------
package pba_pkg;

   localparam int WORD_BITS = 32;
   localparam int POS_W     = 5;

   typedef enum logic [1:0] {
      OP_ALLOC = 2'd0,
      OP_SET   = 2'd1,
      OP_GET   = 2'd2,
      OP_XLATE = 2'd3
   } op_type;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NO_PAGE  = 2'd1;
   localparam logic [1:0] ST_NO_BLOCK = 2'd2;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_FETCH,
      S_SETWR,
      S_GETBIT,
      S_XDIV,
      S_XADD,
      S_SCANP,
      S_SCANB,
      S_COMMIT,
      S_RESP
   } state_type;

   // result of a lowest-zero search over one bitmap word
   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] pos;
   } ffz_type;

endpackage

@@ src/page_block_allocator_unit.sv @@
`timescale 1ns / 1ps
// Allocate scans one 32-bit word per cycle through the shared search unit, first for
//   the pages and then for the blocks.
// Throughput: one request at a time; req_ready is low until the response transfers.
// Reset: synchronous; a clearing pass over all NUM_PAGES table entries then marks every
//   page and block used and loads the identity map before req_ready rises.
// ----------------------------------------------------------------------------
// page_block_allocator_unit
// Page and block allocator with use bitmaps and a block-to-page index table.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module page_block_allocator_unit #(
   parameter int NUM_PAGES = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [9:0]  req_page_number,
   input  logic        req_use_bit,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [9:0]  rsp_block_number,
   output logic        rsp_use_flag,
   output logic [10:0] rsp_directory_address
);
   import pba_pkg::*;

   localparam int IW    = $clog2(NUM_PAGES);
   localparam int WORDS = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
   localparam int WA    = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int AW    = 17;

   // storage
   logic [WORD_BITS-1:0] page_mem [WORDS];
   logic [WORD_BITS-1:0] block_mem [WORDS];
   logic [IW-1:0]        b2p_mem [NUM_PAGES];

   state_type            state_ff, state_in;
   op_type               op_ff, op_in;
   logic [IW-1:0]        idx_ff, idx_in;
   logic                 bit_ff, bit_in;
   logic [IW-1:0]        clr_ptr_ff, clr_ptr_in;
   logic [WA:0]          scan_ptr_ff, scan_ptr_in;
   logic [WA-1:0]        chk_ptr_ff, chk_ptr_in;
   logic                 chk_vld_ff, chk_vld_in;
   logic [IW-1:0]        page_sel_ff, page_sel_in;
   logic [WORD_BITS-1:0] pword_ff, pword_in;
   logic [IW-1:0]        blk_sel_ff, blk_sel_in;
   logic [WORD_BITS-1:0] bword_ff, bword_in;
   logic [6:0]           quot_ff, quot_in;
   logic [1:0]           status_ff, status_in;
   logic [9:0]           blk_out_ff, blk_out_in;
   logic                 flag_ff, flag_in;
   logic [10:0]          addr_ff, addr_in;

   logic [WORD_BITS-1:0] page_rdata_ff, block_rdata_ff;
   logic [IW-1:0]        b2p_rdata_ff;
   logic [WA-1:0]        page_raddr, block_raddr;
   logic [IW-1:0]        b2p_raddr;

   logic                 page_we, block_we, b2p_we;
   logic [WA-1:0]        page_waddr, block_waddr;
   logic [WORD_BITS-1:0] page_wdata, block_wdata;
   logic [IW-1:0]        b2p_waddr, b2p_wdata;

   logic [WORD_BITS-1:0] scan_word;
   ffz_type              ffz;
   logic                 in_range;
   logic [WA-1:0]        idx_word;
   logic [POS_W-1:0]     idx_bit;
   logic [IW-1:0]        found_idx;
   logic [AW-1:0]        page_ext;

   assign in_range  = 32'(req_page_number) < NUM_PAGES;
   assign idx_word  = WA'(idx_ff >> POS_W);
   assign idx_bit   = POS_W'(idx_ff);
   assign found_idx = IW'({chk_ptr_ff, ffz.pos});
   assign page_ext  = AW'(b2p_rdata_ff);

   assign scan_word = (state_ff == S_SCANB) ? block_rdata_ff : page_rdata_ff;

   pba_ffz u_ffz (
      .word   (scan_word),
      .result (ffz)
   );

   // memories
   assign page_raddr  = (state_ff == S_FETCH) ? idx_word : scan_ptr_ff[WA-1:0];
   assign block_raddr = scan_ptr_ff[WA-1:0];
   assign b2p_raddr   = idx_ff;

   always_ff @(posedge clock) begin
      if (page_we) begin
         page_mem[page_waddr] <= page_wdata;
      end
      page_rdata_ff <= page_mem[page_raddr];
   end

   always_ff @(posedge clock) begin
      if (block_we) begin
         block_mem[block_waddr] <= block_wdata;
      end
      block_rdata_ff <= block_mem[block_raddr];
   end

   always_ff @(posedge clock) begin
      if (b2p_we) begin
         b2p_mem[b2p_waddr] <= b2p_wdata;
      end
      b2p_rdata_ff <= b2p_mem[b2p_raddr];
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLEAR;
         clr_ptr_ff  <= '0;
         scan_ptr_ff <= '0;
         chk_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_ptr_ff  <= clr_ptr_in;
         scan_ptr_ff <= scan_ptr_in;
         chk_vld_ff  <= chk_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      idx_ff      <= idx_in;
      bit_ff      <= bit_in;
      chk_ptr_ff  <= chk_ptr_in;
      page_sel_ff <= page_sel_in;
      pword_ff    <= pword_in;
      blk_sel_ff  <= blk_sel_in;
      bword_ff    <= bword_in;
      quot_ff     <= quot_in;
      status_ff   <= status_in;
      blk_out_ff  <= blk_out_in;
      flag_ff     <= flag_in;
      addr_ff     <= addr_in;
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      idx_in      = idx_ff;
      bit_in      = bit_ff;
      clr_ptr_in  = clr_ptr_ff;
      scan_ptr_in = scan_ptr_ff;
      chk_ptr_in  = chk_ptr_ff;
      chk_vld_in  = chk_vld_ff;
      page_sel_in = page_sel_ff;
      pword_in    = pword_ff;
      blk_sel_in  = blk_sel_ff;
      bword_in    = bword_ff;
      quot_in     = quot_ff;
      status_in   = status_ff;
      blk_out_in  = blk_out_ff;
      flag_in     = flag_ff;
      addr_in     = addr_ff;

      page_we     = 1'b0;
      page_waddr  = idx_word;
      page_wdata  = page_rdata_ff;
      block_we    = 1'b0;
      block_waddr = WA'(blk_sel_ff >> POS_W);
      block_wdata = bword_ff | (WORD_BITS'(1) << POS_W'(blk_sel_ff));
      b2p_we      = 1'b0;
      b2p_waddr   = blk_sel_ff;
      b2p_wdata   = page_sel_ff;

      unique case (state_ff)
         S_CLEAR: begin
            // mark everything used, load the identity map
            b2p_we    = 1'b1;
            b2p_waddr = clr_ptr_ff;
            b2p_wdata = clr_ptr_ff;
            if (32'(clr_ptr_ff) < WORDS) begin
               page_we     = 1'b1;
               page_waddr  = WA'(clr_ptr_ff);
               page_wdata  = '1;
               block_we    = 1'b1;
               block_waddr = WA'(clr_ptr_ff);
               block_wdata = '1;
            end
            clr_ptr_in = clr_ptr_ff + 1'b1;
            if (clr_ptr_ff == IW'(NUM_PAGES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               op_in       = op_type'(req_operation);
               idx_in      = IW'(req_page_number);
               bit_in      = req_use_bit;
               status_in   = ST_OK;
               blk_out_in  = '0;
               flag_in     = 1'b0;
               addr_in     = '0;
               scan_ptr_in = '0;
               chk_vld_in  = 1'b0;
               if (op_type'(req_operation) == OP_ALLOC) begin
                  state_in = S_SCANP;
               end else if (in_range) begin
                  state_in = S_FETCH;
               end else begin
                  state_in = S_RESP;
               end
            end
         end
         S_FETCH: begin
            unique case (op_ff)
               OP_SET:   state_in = S_SETWR;
               OP_GET:   state_in = S_GETBIT;
               OP_XLATE: state_in = S_XDIV;
               default:  state_in = S_RESP;
            endcase
         end
         S_SETWR: begin
            page_we    = 1'b1;
            page_wdata = page_rdata_ff;
            page_wdata[idx_bit] = bit_ff;
            state_in   = S_RESP;
         end
         S_GETBIT: begin
            flag_in  = page_rdata_ff[idx_bit];
            state_in = S_RESP;
         end
         S_XDIV: begin
            // page / 1023 without a divider, exact for pages below 1023*128 at these widths
            quot_in  = 7'((page_ext + (page_ext >> 10) + AW'(1)) >> 10);
            state_in = S_XADD;
         end
         S_XADD: begin
            // quotient*1024 + remainder + 1 collapses to page + quotient + 1
            addr_in  = 11'(page_ext + AW'(quot_ff) + AW'(1));
            state_in = S_RESP;
         end
         S_SCANP, S_SCANB: begin
            // issue the next word read while checking the previous one
            if (32'(scan_ptr_ff) < WORDS) begin
               scan_ptr_in = scan_ptr_ff + 1'b1;
               chk_ptr_in  = scan_ptr_ff[WA-1:0];
               chk_vld_in  = 1'b1;
            end else begin
               chk_vld_in  = 1'b0;
            end
            if (chk_vld_ff && ffz.found) begin
               scan_ptr_in = '0;
               chk_vld_in  = 1'b0;
               if (state_ff == S_SCANP) begin
                  page_sel_in = found_idx;
                  pword_in    = scan_word;
                  state_in    = S_SCANB;
               end else begin
                  blk_sel_in  = found_idx;
                  bword_in    = scan_word;
                  state_in    = S_COMMIT;
               end
            end else if (chk_vld_ff && chk_ptr_ff == WA'(WORDS - 1)) begin
               status_in = (state_ff == S_SCANP) ? ST_NO_PAGE : ST_NO_BLOCK;
               state_in  = S_RESP;
            end
         end
         S_COMMIT: begin
            page_we    = 1'b1;
            page_waddr = WA'(page_sel_ff >> POS_W);
            page_wdata = pword_ff | (WORD_BITS'(1) << POS_W'(page_sel_ff));
            block_we   = 1'b1;
            b2p_we     = 1'b1;
            blk_out_in = 10'(blk_sel_ff);
            state_in   = S_RESP;
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req_ready             = (state_ff == S_IDLE);
   assign rsp_valid             = (state_ff == S_RESP);
   assign rsp_status            = status_ff;
   assign rsp_block_number      = blk_out_ff;
   assign rsp_use_flag          = flag_ff;
   assign rsp_directory_address = addr_ff;

   `PBA_ASSERT(a_one_side, clock, reset, !(req_ready && rsp_valid))
   `PBA_ASSERT(a_busy_after_req, clock, reset, (req_valid && req_ready) |=> !req_ready)
   `PBA_ASSERT(a_fail_no_block, clock, reset, (rsp_valid && rsp_status != ST_OK) |-> (rsp_block_number == '0))
   `PBA_ASSERT(a_clear_blocks, clock, reset, (state_ff == S_CLEAR) |-> (!req_ready && !rsp_valid))

endmodule

@@ src/pba_ffz.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pba_ffz
// Shared search unit: lowest clear bit of one 32-bit bitmap word.
// ----------------------------------------------------------------------------
module pba_ffz (
   input  logic [pba_pkg::WORD_BITS-1:0] word,
   output pba_pkg::ffz_type              result
);
   import pba_pkg::*;

   always_comb begin
      result = '0;
      // scan from the top so the lowest clear bit wins
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (!word[i]) begin
            result.found = 1'b1;
            result.pos   = POS_W'(i);
         end
      end
   end

endmodule

@@ tb/page_block_allocator_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_block_allocator_unit_tb
// Drives allocate, set use, get use and translate requests into the allocator
// and checks every response against a model of the page and block bitmaps and
// the block-to-page table, under several sender and receiver flow-control mixes.
// ----------------------------------------------------------------------------
module page_block_allocator_unit_tb;
   import pba_pkg::*;

   localparam int PAGE_COUNT = 1024;

   typedef struct packed {
      logic [1:0]  status;
      logic [9:0]  block_number;
      logic        use_flag;
      logic [10:0] directory_address;
   } pba_result;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_operation = OP_GET;
   logic [9:0]  req_page_number = '0;
   logic        req_use_bit = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [9:0]  rsp_block_number;
   logic        rsp_use_flag;
   logic [10:0] rsp_directory_address;

   // model state
   logic        page_used_model [PAGE_COUNT];
   logic        block_used_model [PAGE_COUNT];
   logic [9:0]  block_page_model [PAGE_COUNT];

   pba_result   pending_results [$];
   int          sender_idle_pct = 0;
   int          receiver_stall_pct = 0;
   int          hold_off_cycles = 0;
   int          request_count = 0;
   int          response_count = 0;
   int          error_count = 0;
   int          alloc_fail_count = 0;

   page_block_allocator_unit dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_operation         (req_operation),
      .req_page_number       (req_page_number),
      .req_use_bit           (req_use_bit),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_status            (rsp_status),
      .rsp_block_number      (rsp_block_number),
      .rsp_use_flag          (rsp_use_flag),
      .rsp_directory_address (rsp_directory_address)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // receiver: a long hold-off takes priority over the random stall mix
   always @(negedge clock) begin
      if (hold_off_cycles > 0) begin
         rsp_ready <= 1'b0;
         hold_off_cycles = hold_off_cycles - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   function automatic logic [10:0] directory_word(input int page);
      int word;
      word = (page / 1023) * 1024 + (page % 1023) + 1;
      return word[10:0];
   endfunction

   function automatic pba_result predict_response(input op_type op,
                                                  input logic [9:0] idx,
                                                  input logic ubit);
      pba_result want;
      int free_page;
      int free_block;
      want = '0;
      want.status = ST_OK;
      case (op)
         OP_ALLOC: begin
            free_page = PAGE_COUNT;
            free_block = PAGE_COUNT;
            for (int i = PAGE_COUNT - 1; i >= 0; i--) begin
               if (!page_used_model[i]) free_page = i;
               if (!block_used_model[i]) free_block = i;
            end
            // a missing page wins over a missing block
            if (free_page >= PAGE_COUNT) begin
               want.status = ST_NO_PAGE;
            end else if (free_block >= PAGE_COUNT) begin
               want.status = ST_NO_BLOCK;
            end else begin
               block_page_model[free_block] = free_page[9:0];
               block_used_model[free_block] = 1'b1;
               page_used_model[free_page] = 1'b1;
               want.block_number = free_block[9:0];
            end
         end
         OP_SET: begin
            if (idx < PAGE_COUNT) page_used_model[idx] = ubit;
         end
         OP_GET: begin
            if (idx < PAGE_COUNT) want.use_flag = page_used_model[idx];
         end
         default: begin
            if (idx < PAGE_COUNT) want.directory_address = directory_word(block_page_model[idx]);
         end
      endcase
      return want;
   endfunction

   // leaves valid high after the transfer; the next call or a drain drops it
   task automatic send_request(input op_type op, input logic [9:0] idx, input logic ubit);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_page_number <= idx;
      req_use_bit <= ubit;
      do @(posedge clock); while (!req_ready);
      pending_results.push_back(predict_response(op, idx, ubit));
      request_count++;
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin : check_responses
      pba_result want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("response transfer with no request outstanding");
            error_count++;
         end else begin
            want = pending_results.pop_front();
            response_count++;
            if (rsp_status != ST_OK) alloc_fail_count++;
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               error_count++;
            end
            if (rsp_block_number !== want.block_number) begin
               $error("block_number: expected %0d, got %0d",
                      want.block_number, rsp_block_number);
               error_count++;
            end
            if (rsp_use_flag !== want.use_flag) begin
               $error("use_flag: expected %0d, got %0d", want.use_flag, rsp_use_flag);
               error_count++;
            end
            if (rsp_directory_address !== want.directory_address) begin
               $error("directory_address: expected %0d, got %0d",
                      want.directory_address, rsp_directory_address);
               error_count++;
            end
         end
      end
   end

   task automatic test_reset_contents();
      send_request(OP_GET, 10'd0, 1'b0);
      send_request(OP_GET, 10'h3FF, 1'b0);
      send_request(OP_GET, 10'h200, 1'b0);
      send_request(OP_XLATE, 10'd0, 1'b0);
      send_request(OP_XLATE, 10'd1, 1'b0);
      send_request(OP_XLATE, 10'd1022, 1'b0);
      send_request(OP_XLATE, 10'h3FF, 1'b1);
      // everything is used out of reset
      send_request(OP_ALLOC, 10'd0, 1'b0);
   endtask

   task automatic test_use_bits();
      send_request(OP_SET, 10'd0, 1'b0);
      send_request(OP_GET, 10'd0, 1'b1);
      send_request(OP_SET, 10'h3FF, 1'b0);
      send_request(OP_GET, 10'h3FF, 1'b0);
      send_request(OP_XLATE, 10'h3FF, 1'b0);
      // free page but no free block
      send_request(OP_ALLOC, 10'h3FF, 1'b1);
      send_request(OP_SET, 10'd0, 1'b1);
      send_request(OP_SET, 10'h3FF, 1'b1);
      send_request(OP_ALLOC, 10'h2AA, 1'b1);
      send_request(OP_GET, 10'd0, 1'b0);
   endtask

   task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                      input int item_count);
      logic [9:0] idx;
      int roll;
      wait_for_results();
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
      for (int n = 0; n < item_count; n++) begin
         // favor a few low pages so written bits get read back
         idx = ($urandom_range(3) == 0) ? 10'($urandom_range(15)) : 10'($urandom_range(1023));
         roll = $urandom_range(99);
         if (roll < 15) send_request(OP_ALLOC, idx, 1'($urandom_range(1)));
         else if (roll < 45) send_request(OP_SET, idx, 1'($urandom_range(1)));
         else if (roll < 75) send_request(OP_GET, idx, 1'($urandom_range(1)));
         else send_request(OP_XLATE, idx, 1'($urandom_range(1)));
      end
   endtask

   task automatic test_output_backpressure();
      wait_for_results();
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      @(posedge clock);
      hold_off_cycles = 300;
      for (int n = 0; n < 6; n++) begin
         send_request(n % 2 ? OP_XLATE : OP_GET, 10'($urandom_range(1023)), 1'b0);
      end
      send_request(OP_ALLOC, 10'd0, 1'b0);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int i = 0; i < PAGE_COUNT; i++) begin
         page_used_model[i] = 1'b1;
         block_used_model[i] = 1'b1;
         block_page_model[i] = 10'(i);
      end

      test_reset_contents();
      test_use_bits();
      test_random_traffic(0, 0, 130);
      test_random_traffic(85, 0, 130);
      test_output_backpressure();
      test_random_traffic(0, 85, 130);
      test_random_traffic(29, 29, 140);
      wait_for_results();

      // allow for a stray late transfer
      repeat (100) @(posedge clock);
      if (pending_results.size() != 0) begin
         $error("%0d responses never arrived", pending_results.size());
         error_count++;
      end
      $display("Checked %0d responses for %0d requests (%0d allocate failures) across",
               response_count, request_count, alloc_fail_count);
      $display("reset contents, use bits, translate and four flow-control mixes with hold-off.");
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // 10 ms: many times the slowest expected run
   initial begin
      #10_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

@@ page_block_allocator_unit.f @@
+incdir+src
src/pba_pkg.sv
src/pba_ffz.sv
src/page_block_allocator_unit.sv
tb/page_block_allocator_unit_tb.sv
